// ===== hdl/ca_cfar_2d_detector_defines.svh =====
// Assertion macros shared by the detector RTL
`ifndef CA_CFAR_2D_DETECTOR_DEFINES_SVH
`define CA_CFAR_2D_DETECTOR_DEFINES_SVH

// Check on clk, suppressed while rst is high
`define CFAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on clk that also runs during reset
`define CFAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cfar2d_pkg.sv =====
package cfar2d_pkg;

  // Map geometry and window shape
  localparam int ROW_LEN       = 256;
  localparam int ROW_COUNT     = 128;
  localparam int TRAIN_RANGE   = 8;
  localparam int TRAIN_DOPPLER = 4;
  localparam int GUARD_RANGE   = 2;
  localparam int GUARD_DOPPLER = 2;

  localparam int HALF_R     = TRAIN_RANGE + GUARD_RANGE;
  localparam int HALF_D     = TRAIN_DOPPLER + GUARD_DOPPLER;
  localparam int WIN_ROWS   = 2 * HALF_D + 1;
  localparam int WIN_COLS   = 2 * HALF_R + 1;
  localparam int GUARD_ROWS = 2 * GUARD_DOPPLER + 1;
  localparam int GUARD_COLS = 2 * GUARD_RANGE + 1;
  localparam int HIST_ROWS  = WIN_ROWS - 1;
  localparam int N_TRAIN    = WIN_COLS * WIN_ROWS - GUARD_COLS * GUARD_ROWS;

  // Widths
  localparam int PWR_W    = 32;
  localparam int TF_W     = 16;
  localparam int TF_RESET = 3635;
  localparam int COL_W    = $clog2(ROW_LEN);
  localparam int ROW_W    = $clog2(ROW_COUNT);
  localparam int DOPP_W   = 7;
  localparam int RANGE_W  = 8;
  localparam int NOISE_W  = 40;
  localparam int GSUM_W   = PWR_W + $clog2(GUARD_ROWS + 1);
  localparam int CSUM_W   = PWR_W + $clog2(WIN_ROWS + 1);
  localparam int WSUM_W   = PWR_W + $clog2(WIN_ROWS * WIN_COLS + 1);
  localparam int GT_W     = GSUM_W + $clog2(GUARD_COLS + 1);
  localparam int NTR_W    = $clog2(N_TRAIN + 1);
  localparam int LHS_W    = PWR_W + NTR_W;
  localparam int PROD_W   = TF_W + WSUM_W;
  localparam int LINE_W   = PWR_W * HIST_ROWS;

  // Result packing: doppler_bin lowest
  localparam int RES_W    = DOPP_W + RANGE_W + 1 + PWR_W + NOISE_W;
  localparam int OUT_W    = ((RES_W + 7) / 8) * 8;
  localparam int IN_W     = PWR_W;

  // APB register map
  localparam int          PADDR_W       = 3;
  localparam logic [0:0]  REG_THRESHOLD = 1'b0;

  // One column of the window as it moves through the cell chain
  typedef struct packed {
    logic [CSUM_W-1:0] wsum;
    logic [GSUM_W-1:0] gsum;
    logic [PWR_W-1:0]  ctr;
  } col_t;

  // Position of the cell under test
  typedef struct packed {
    logic             test;
    logic [ROW_W-1:0] cd;
    logic [COL_W-1:0] cr;
  } meta_t;

  typedef struct packed {
    logic [NOISE_W-1:0] noise_sum;
    logic [PWR_W-1:0]   tested_power;
    logic               detected;
    logic [RANGE_W-1:0] range_bin;
    logic [DOPP_W-1:0]  doppler_bin;
  } res_t;

  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } q_status_t;

endpackage

// ===== hdl/ca_cfar_2d_detector.sv =====
// A result passes stages 0 to 5 and then the result queue before it is offered on m_tvalid.
// Throughput: one cell per cycle; the range window is a chain of column cells with a
// running sum, and the line store is one read and one write of a RAM each cycle.
// Input stalls only when the two-entry result queue is full.
// Reset (rst, synchronous) clears positions, pipeline valids, column cells, running
// sum and result queue, and sets threshold_factor to 3635; the line RAM is not cleared.
`include "ca_cfar_2d_detector_defines.svh"

module ca_cfar_2d_detector
  import cfar2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // APB configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // cells in
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,   // [31:0] cell_power
  input  logic               s_tuser,   // [0] frame_start
  // results out
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata    // doppler_bin, range_bin, detected,
                                        // tested_power, noise_sum (low bit up)
);

  logic [TF_W-1:0]   threshold_factor;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row_cur;
  logic [COL_W-1:0]  col_cur;
  logic              en;
  logic              accept;
  q_status_t         q_stat;

  // stage 0
  logic              v0;
  logic [PWR_W-1:0]  s0_power;
  logic [COL_W-1:0]  s0_col;
  logic [ROW_W-1:0]  s0_row;
  meta_t             s0_meta;
  logic [LINE_W-1:0] line_rdata;
  logic [LINE_W-1:0] line_wdata;
  logic [PWR_W-1:0]  colv [WIN_ROWS];

  // stage 1
  logic              v1;
  meta_t             s1_meta;
  logic [GSUM_W-1:0] s1_g;
  logic [CSUM_W-1:0] s1_o1;
  logic [CSUM_W-1:0] s1_o2;
  logic [PWR_W-1:0]  s1_ctr;
  logic [GSUM_W-1:0] g_comb;
  logic [CSUM_W-1:0] o1_comb;
  logic [CSUM_W-1:0] o2_comb;

  // stage 2
  logic              v2;
  meta_t             s2_meta;
  col_t              s2_col;

  // chain
  logic              v3;
  meta_t             s3_meta;
  col_t              taps [WIN_COLS];
  logic [WSUM_W-1:0] run_sum;
  logic              shift;

  // stage 4
  logic              v4;
  meta_t             s4_meta;
  logic [PWR_W-1:0]  s4_cut;
  logic [WSUM_W-1:0] s4_noise;
  logic [GT_W-1:0]   gtot;

  // stage 5
  logic              v5;
  meta_t             s5_meta;
  logic [PWR_W-1:0]  s5_cut;
  logic [NOISE_W-1:0] s5_noise;
  logic [LHS_W-1:0]  s5_lhs;
  logic [PROD_W-1:0] s5_rhs;
  res_t              res;
  logic              push;

  // Pipeline moves whenever the result queue has room
  assign en       = !q_stat.full;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {{(32 - TF_W){1'b0}}, threshold_factor} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_factor <= TF_W'(TF_RESET);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      threshold_factor <= pwdata[TF_W-1:0];
    end
  end

  // Position counters
  assign row_cur = s_tuser ? '0 : row;
  assign col_cur = s_tuser ? '0 : col;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (col_cur == COL_W'(ROW_LEN - 1)) begin
        col <= '0;
        row <= (row_cur == ROW_W'(ROW_COUNT - 1)) ? '0 : row_cur + ROW_W'(1);
      end else begin
        col <= col_cur + COL_W'(1);
        row <= row_cur;
      end
    end
  end

  // Stage 0: capture cell, read previous rows of its column
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_power     <= s_tdata[PWR_W-1:0];
      s0_col       <= col_cur;
      s0_row       <= row_cur;
      s0_meta.test <= (row_cur >= ROW_W'(2 * HALF_D)) && (col_cur >= COL_W'(2 * HALF_R));
      s0_meta.cd   <= row_cur - ROW_W'(HALF_D);
      s0_meta.cr   <= col_cur - COL_W'(HALF_R);
    end
  end

  cfar2d_ram #(
    .WIDTH(LINE_W),
    .DEPTH(ROW_LEN)
  ) u_line (
    .clk  (clk),
    .we   (en && v0),
    .waddr(s0_col),
    .wdata(line_wdata),
    .re   (en),
    .raddr(col_cur),
    .rdata(line_rdata)
  );

  // Column of the window, newest row first; rows above the frame's first row read as zero
  // Write back shifted by one row
  always_comb begin
    colv[0] = s0_power;
    for (int k = 1; k < WIN_ROWS; k++) begin
      colv[k] = (s0_row >= ROW_W'(k)) ? line_rdata[PWR_W*(k-1) +: PWR_W] : '0;
    end
    line_wdata[PWR_W-1:0] = s0_power;
    for (int k = 1; k < HIST_ROWS; k++) begin
      line_wdata[PWR_W*k +: PWR_W] = line_rdata[PWR_W*(k-1) +: PWR_W];
    end
  end

  // Column partial sums: guard rows and the two training bands
  always_comb begin
    g_comb  = '0;
    o1_comb = '0;
    o2_comb = '0;
    for (int k = 0; k < GUARD_ROWS; k++) begin
      g_comb = g_comb + GSUM_W'(colv[TRAIN_DOPPLER + k]);
    end
    for (int k = 0; k < TRAIN_DOPPLER; k++) begin
      o1_comb = o1_comb + CSUM_W'(colv[k]);
      o2_comb = o2_comb + CSUM_W'(colv[WIN_ROWS - 1 - k]);
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_meta <= s0_meta;
      s1_g    <= g_comb;
      s1_o1   <= o1_comb;
      s1_o2   <= o2_comb;
      s1_ctr  <= colv[HALF_D];
    end
  end

  // Stage 2: full window column sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_meta     <= s1_meta;
      s2_col.wsum <= CSUM_W'(s1_g) + s1_o1 + s1_o2;
      s2_col.gsum <= s1_g;
      s2_col.ctr  <= s1_ctr;
    end
  end

  // Cell chain over the range window, newest column in tap 0
  assign shift = en && v2;

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_chain
    if (k == 0) begin : g_head
      cfar2d_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .din  (s2_col),
        .dout (taps[k])
      );
    end else begin : g_body
      cfar2d_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .din  (taps[k-1]),
        .dout (taps[k])
      );
    end
  end

  // Running sum of all window columns in the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum <= '0;
    end else if (shift) begin
      run_sum <= run_sum + WSUM_W'(s2_col.wsum) - WSUM_W'(taps[WIN_COLS-1].wsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_meta <= s2_meta;
    end
  end

  // Stage 4: remove guard columns, pick the cell under test
  always_comb begin
    gtot = '0;
    for (int k = 0; k < GUARD_COLS; k++) begin
      gtot = gtot + GT_W'(taps[TRAIN_RANGE + k].gsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3 && s3_meta.test;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_meta  <= s3_meta;
      s4_cut   <= taps[HALF_R].ctr;
      s4_noise <= run_sum - WSUM_W'(gtot);
    end
  end

  // Stage 5: both sides of the threshold test
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_meta  <= s4_meta;
      s5_cut   <= s4_cut;
      s5_noise <= s4_noise[NOISE_W-1:0];
      s5_lhs   <= LHS_W'(s4_cut) * LHS_W'(N_TRAIN);
      s5_rhs   <= PROD_W'(threshold_factor) * PROD_W'(s4_noise);
    end
  end

  // Compare and hand to the result queue
  assign push             = en && v5;
  assign res.doppler_bin  = DOPP_W'(s5_meta.cd);
  assign res.range_bin    = RANGE_W'(s5_meta.cr);
  assign res.detected     = (PROD_W'({s5_lhs, 8'd0}) > s5_rhs);
  assign res.tested_power = s5_cut;
  assign res.noise_sum    = s5_noise;

  cfar2d_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (res),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .stat    (q_stat)
  );

  `CFAR_ASSERT(a_cut_range, v4 |-> (s4_meta.cr >= COL_W'(HALF_R)), "tested column off the window")
  `CFAR_ASSERT(a_stall_sum, !en |=> $stable(run_sum), "running sum moved during a stall")
  `CFAR_ASSERT(a_stall_result, (v5 && !en) |=> v5, "pending result lost during a stall")
  `CFAR_ASSERT_ALWAYS(a_reset_out, rst |=> !m_tvalid, "result offered right after reset")

endmodule

// ===== hdl/cfar2d_ram.sv =====
module cfar2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/cfar2d_cell.sv =====
module cfar2d_cell
  import cfar2d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  col_t din,
  output col_t dout
);

  // One column slot of the range window; cleared so the running sum starts at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else if (shift) begin
      dout <= din;
    end
  end

endmodule

// ===== hdl/cfar2d_outq.sv =====
module cfar2d_outq
  import cfar2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_t              din,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output q_status_t         stat
);

  res_t       e0;
  res_t       e1;
  logic [1:0] count;
  logic       pop;

  assign pop        = m_tvalid && m_tready;
  assign m_tvalid   = (count != 2'd0);
  assign m_tdata    = OUT_W'(e0);
  assign stat.count = count;
  assign stat.full  = (count == 2'd2);

  // Two-entry result queue, head in e0
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (count == 2'd0) begin
            e0 <= din;
          end else begin
            e1 <= din;
          end
          count <= count + 2'd1;
        end
        2'b01: begin
          e0    <= e1;
          count <= count - 2'd1;
        end
        2'b11: begin
          if (count == 2'd1) begin
            e0 <= din;
          end else begin
            e0 <= e1;
            e1 <= din;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== tb/ca_cfar_2d_detector_tb.sv =====
module ca_cfar_2d_detector_tb;
  import cfar2d_pkg::*;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               s_tvalid;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata;   // [31:0] cell_power
  logic               s_tuser;   // [0] frame_start
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;   // doppler_bin, range_bin, detected,
                                 // tested_power, noise_sum (low bit up)

  ca_cfar_2d_detector dut (.*);

  // Shadow of the detector state
  logic [PWR_W-1:0] shadow_lines [WIN_ROWS][ROW_LEN];
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [TF_W-1:0]  alpha_q88;
  res_t             pending_reports [$];

  int errors;
  int reports_seen;
  bit idle_on;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 4_000_000);
    $display("ca_cfar_2d_detector_tb: FAIL");
    $finish;
  end

  // Random gap length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Window test for the newest cell, queues the expected report if any
  function automatic void cfar_predict(logic [PWR_W-1:0] pwr, bit start);
    int unsigned cd, cr, ai, aj;
    logic [63:0] noise, lhs, rhs;
    logic [PWR_W-1:0] cut;
    res_t r;
    if (start) begin
      row_pos = 0;
      col_pos = 0;
    end
    shadow_lines[row_pos % WIN_ROWS][col_pos] = pwr;
    if (row_pos >= 2 * HALF_D && col_pos >= 2 * HALF_R) begin
      cd = row_pos - HALF_D;
      cr = col_pos - HALF_R;
      noise = '0;
      for (int i = -HALF_D; i <= HALF_D; i++) begin
        for (int j = -HALF_R; j <= HALF_R; j++) begin
          ai = (i < 0) ? -i : i;
          aj = (j < 0) ? -j : j;
          if (ai > GUARD_DOPPLER || aj > GUARD_RANGE)
            noise += shadow_lines[(cd + i) % WIN_ROWS][cr + j];
        end
      end
      cut = shadow_lines[cd % WIN_ROWS][cr];
      lhs = 64'(cut) * 64'(N_TRAIN) * 64'd256;
      rhs = 64'(alpha_q88) * noise;
      r.doppler_bin  = cd[DOPP_W-1:0];
      r.range_bin    = cr[RANGE_W-1:0];
      r.detected     = lhs > rhs;
      r.tested_power = cut;
      r.noise_sum    = noise[NOISE_W-1:0];
      pending_reports = {pending_reports, r};
    end
    col_pos++;
    if (col_pos >= ROW_LEN) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= ROW_COUNT) row_pos = 0;
    end
  endfunction

  // Cell power mix: zeros, full scale, wide random, low noise with spikes
  function automatic logic [PWR_W-1:0] pick_power();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return '0;
    if (r < 4) return '1;
    if (r < 6) return $urandom;
    if (r == 6) return $urandom_range(100000, 10000000);
    return $urandom_range(0, 1000);
  endfunction

  // Send one cell transaction and update the shadow on acceptance
  task automatic send_cell(logic [PWR_W-1:0] pwr, bit start);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pwr;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
    cfar_predict(pwr, start);
  endtask

  task automatic send_cells(int n, bit first_start);
    for (int k = 0; k < n; k++) send_cell(pick_power(), first_start && k == 0);
  endtask

  // Drain outstanding reports, then allow for pipeline latency
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == 4 * REG_THRESHOLD) alpha_q88 = data[TF_W-1:0];
  endtask

  // Result checker
  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] got);
    if (exp !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[RES_W-1:0]);
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %0h", $time, got);
        errors++;
      end else begin
        exp = pending_reports.pop_front();
        check_field("doppler_bin", exp.doppler_bin, got.doppler_bin);
        check_field("range_bin", exp.range_bin, got.range_bin);
        check_field("detected", exp.detected, got.detected);
        check_field("tested_power", exp.tested_power, got.tested_power);
        check_field("noise_sum", exp.noise_sum, got.noise_sum);
      end
      reports_seen++;
    end
  end

  // Receiver: random stalls, plus a counted hold-off when requested
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      gap = pick_gap();
      m_tready <= (gap == 0);
    end
  end

  // Reset threshold, full-scale and zero cells across the first windows
  task automatic test_reset_threshold();
    idle_on = 1'b0;
    for (int k = 0; k < 2 * HALF_D * ROW_LEN + 40; k++)
      send_cell((k % 7 == 0) ? '0 : '1, k == 0);
    wait_idle();
  endtask

  // Threshold extremes, unity gain ties, ignored register index
  task automatic test_threshold_extremes();
    logic [31:0] settings [4];
    settings = '{32'h0, 32'hFFFF, 32'h100, 32'hABCD_1234};
    idle_on = 1'b1;
    apb_write(PADDR_W'(4), 32'h55);
    foreach (settings[s]) begin
      apb_write(PADDR_W'(4 * REG_THRESHOLD), settings[s]);
      for (int k = 0; k < 40; k++)
        send_cell((s == 2 && k % 3 != 0) ? 32'd5000 : pick_power(), 1'b0);
      wait_idle();
    end
  endtask

  // Mid-frame restart: results stop until the window fills again
  task automatic test_wrap_and_restart();
    apb_write(PADDR_W'(4 * REG_THRESHOLD), 32'd3635);
    idle_on = 1'b0;
    send_cells(60, 1'b1);
    wait_idle();
  endtask

  // Receiver holds off while cells keep coming, so the input stalls
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cycles = 300;
    send_cells(150, 1'b0);
    wait_idle();
  endtask

  // Random stream across a row wrap with rare frame restarts and threshold changes
  task automatic test_random();
    int sent;
    idle_on = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      apb_write(PADDR_W'(4 * REG_THRESHOLD),
                (phase == 0) ? 32'd512 : $urandom_range(0, 65535));
      sent = 0;
      while (sent < 80) begin
        send_cell(pick_power(), $urandom_range(0, 9999) == 0);
        sent++;
      end
      wait_idle();
    end
  endtask

  initial begin
    int guard;
    errors = 0;
    reports_seen = 0;
    idle_on = 1'b0;
    hold_cycles = 0;
    alpha_q88 = TF_RESET;
    row_pos = 0;
    col_pos = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_threshold();
    test_threshold_extremes();
    test_backpressure();
    test_random();
    test_wrap_and_restart();

    s_tvalid <= 1'b0;
    guard = 0;
    while (pending_reports.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("ca_cfar_2d_detector_tb: PASS");
    end else begin
      $display("ca_cfar_2d_detector_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cfar2d_pkg.sv
hdl/cfar2d_ram.sv
hdl/cfar2d_cell.sv
hdl/cfar2d_outq.sv
hdl/ca_cfar_2d_detector.sv
tb/ca_cfar_2d_detector_tb.sv
